// ===== src/rna_pkg.sv =====
// ----------------------------------------------------------------------------
// rna_pkg
// Shared widths, constants and the digit-to-character mapping for the
// radix number to ASCII converter.
// ----------------------------------------------------------------------------
package rna_pkg;

    // Fixed field widths
    localparam int NUMBER_W = 32;
    localparam int RADIX_W  = 6;
    localparam int CHAR_W   = 7;
    localparam int DIGIT_W  = 5;

    // Default value width handed to the top level
    localparam int VALUE_BITS_DEFAULT = 32;

    // Radix register reset value and legal range
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(32);

    // ASCII anchors
    localparam logic [CHAR_W-1:0]  ASCII_ZERO   = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  ASCII_LETTER = CHAR_W'(65 - 10);
    localparam logic [DIGIT_W-1:0] DIGIT_TEN    = DIGIT_W'(10);

    // Digit 0..9 -> '0'..'9', digit 10..31 -> 'A'..'V'
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] base_char;
        base_char = (d >= DIGIT_TEN) ? ASCII_LETTER : ASCII_ZERO;
        return base_char + CHAR_W'(d);
    endfunction

endpackage

// ===== src/radix_number_to_ascii_top.sv =====
// ----------------------------------------------------------------------------
// radix_number_to_ascii_top
// Converts an unsigned value into ASCII digits in a base from 2 to 32,
// one character per result item, most significant digit first.
//
//   channel | direction | ports                                    | item
//   --------+-----------+------------------------------------------+---------------
//   s_      | in        | s_valid s_ready s_number_in              | value
//   m_      | out       | m_valid m_ready m_digit_char m_last_char | one character
//   cfg_    | in        | cfg_wr_en cfg_wr_data                    | radix write
//
// Each digit is a restoring division of the running VALUE_BITS-bit quotient
// in the shared compare/subtract unit (one quotient bit per cycle). All digits
// of an item are divided first; each character is then read from the digit
// store (ST_READ) and presented (ST_SHOW).
// s_ready is high only while idle; an item with an illegal radix is taken
// and gives no result. A stalled m_ready holds the current character.
// Reset is synchronous and active low; the digit store needs no clearing.
// ----------------------------------------------------------------------------
module radix_number_to_ascii_top #(
    parameter int VALUE_BITS = rna_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration
    input  logic                        cfg_wr_en,
    input  logic [rna_pkg::RADIX_W-1:0] cfg_wr_data,
    // Input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rna_pkg::NUMBER_W-1:0] s_number_in,
    // Result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rna_pkg::CHAR_W-1:0]  m_digit_char,
    output logic                        m_last_char
);

    localparam int IDX_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int DW    = rna_pkg::DIGIT_W;
    localparam int RW    = rna_pkg::RADIX_W;
    localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(VALUE_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_SHOW
    } state_t;

    state_t                  state_reg;
    logic [RW-1:0]           radix_reg;
    logic [VALUE_BITS-1:0]   quot_reg;
    logic [VALUE_BITS-1:0]   quot_next;
    logic [DW-1:0]           rem_reg;
    logic [DW-1:0]           rem_next;
    logic [IDX_W-1:0]        bit_cnt_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_inc;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic [DW-1:0]           rd_data_reg;
    logic [DW-1:0]           digit_store [VALUE_BITS];

    logic [2*rna_pkg::NUMBER_W-1:0] number_wide;
    logic [VALUE_BITS-1:0]   number_cut;
    logic                    radix_ok;
    logic                    in_accept;
    logic                    digit_done;
    logic [RW-1:0]           partial;
    logic [RW-1:0]           diff;
    logic                    qbit;

    // Input value limited to VALUE_BITS (zero-extended when wider than the port)
    assign number_wide = {{rna_pkg::NUMBER_W{1'b0}}, s_number_in};
    assign number_cut  = number_wide[VALUE_BITS-1:0];

    assign radix_ok  = (radix_reg >= rna_pkg::RADIX_MIN) && (radix_reg <= rna_pkg::RADIX_MAX);
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;

    // Shared compare/subtract unit: one restoring division step per cycle
    assign partial   = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign diff      = partial - radix_reg;
    assign qbit      = (partial >= radix_reg);
    assign rem_next  = qbit ? diff[DW-1:0] : partial[DW-1:0];
    assign quot_next = {quot_reg[VALUE_BITS-2:0], qbit};
    assign digit_done = (bit_cnt_reg == LAST_BIT);
    assign count_inc  = count_reg + CNT_W'(1);

    // Radix register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= rna_pkg::RADIX_RESET;
        end else if (cfg_wr_en) begin
            radix_reg <= cfg_wr_data;
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            quot_reg    <= '0;
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
            count_reg   <= '0;
            rd_idx_reg  <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_accept && radix_ok) begin
                        quot_reg    <= number_cut;
                        rem_reg     <= '0;
                        bit_cnt_reg <= '0;
                        count_reg   <= '0;
                        state_reg   <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE: begin
                    quot_reg <= quot_next;
                    if (digit_done) begin
                        // digit finished; a zero quotient ends the division
                        rem_reg     <= '0;
                        bit_cnt_reg <= '0;
                        count_reg   <= count_inc;
                        if (quot_next == '0) begin
                            rd_idx_reg <= count_reg[IDX_W-1:0];
                            state_reg  <= ST_READ;
                        end
                    end else begin
                        rem_reg     <= rem_next;
                        bit_cnt_reg <= bit_cnt_reg + IDX_W'(1);
                    end
                end
                ST_READ: begin
                    state_reg <= ST_SHOW;
                end
                ST_SHOW: begin
                    if (m_ready) begin
                        if (rd_idx_reg == '0) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            rd_idx_reg <= rd_idx_reg - IDX_W'(1);
                            state_reg  <= ST_READ;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Digit store: written at the end of each digit, read in ST_READ before each character is shown
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIVIDE && digit_done) begin
            digit_store[count_reg[IDX_W-1:0]] <= rem_next;
        end
        if (state_reg == ST_READ) begin
            rd_data_reg <= digit_store[rd_idx_reg];
        end
    end

    // Result channel
    assign m_valid      = (state_reg == ST_SHOW);
    assign m_digit_char = rna_pkg::digit_to_ascii(rd_data_reg);
    assign m_last_char  = (rd_idx_reg == '0);

    // Checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("result shown while accepting input");

    a_bad_radix_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && !radix_ok) |=> s_ready)
        else $error("item with illegal radix started a conversion");

    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_char) |=> (s_ready && !m_valid))
        else $error("block not idle after last character");

    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_digit_char >= rna_pkg::ASCII_ZERO && m_digit_char <= 7'd86))
        else $error("character outside digit range");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_digit_char) && $stable(m_last_char)))
        else $error("stalled character changed");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the radix number to ASCII converter. Values are fed through a
// valid/ready driver, every accepted value is spelled out in the current
// radix by a local model, and each character that comes out is compared
// with the oldest character still owed. Radix settings cover both ends of
// the legal range, some in between and a few illegal ones.
// ----------------------------------------------------------------------------
module testbench;

    localparam int VALUE_BITS  = 32;
    localparam int IDLE_PCT    = 14;
    localparam int HOLD_CYCLES = 600;
    // Slowest item is the 32-digit string of base 2
    localparam int DRAIN_CYCLES = 1200;
    localparam int MAX_REPORTS  = 50;

    // ASCII anchors for the local model
    localparam int CHAR_DIGIT0    = 48;
    localparam int CHAR_ALPHA     = 65;
    localparam int DECIMAL_DIGITS = 10;

    typedef struct packed {
        logic [rna_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } ascii_char_t;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [rna_pkg::RADIX_W-1:0]   cfg_wr_data = '0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic [rna_pkg::NUMBER_W-1:0]  s_number_in = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic [rna_pkg::CHAR_W-1:0]    m_digit_char;
    logic                          m_last_char;

    logic [rna_pkg::NUMBER_W-1:0]  value_q[$];
    ascii_char_t                   expected_chars[$];
    logic [rna_pkg::RADIX_W-1:0]   radix_now   = rna_pkg::RADIX_RESET;
    bit                            calm        = 1'b0;
    bit                            hold_done   = 1'b0;
    int                            hold_left   = 0;
    int                            error_count = 0;
    int                            values_taken = 0;
    int                            chars_checked = 0;
    int                            radix_writes = 0;

    radix_number_to_ascii_top #(
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_number_in  (s_number_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last_char  (m_last_char)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Spell a value in the given base, most significant character first
    task automatic spell_number(input logic [rna_pkg::NUMBER_W-1:0] value,
                                input logic [rna_pkg::RADIX_W-1:0] base);
        logic [rna_pkg::DIGIT_W-1:0]  digits [VALUE_BITS];
        logic [rna_pkg::NUMBER_W-1:0] quot;
        int                           n;
        ascii_char_t                  c;
        // illegal radix: value is swallowed
        if (base < rna_pkg::RADIX_MIN || base > rna_pkg::RADIX_MAX)
            return;
        quot = value;
        n = 0;
        while (quot != 0 && n < VALUE_BITS) begin
            digits[n] = rna_pkg::DIGIT_W'(quot % base);
            quot = quot / base;
            n++;
        end
        if (n == 0) begin
            digits[0] = '0;
            n = 1;
        end
        for (int k = n - 1; k >= 0; k--) begin
            if (digits[k] >= DECIMAL_DIGITS)
                c.ch = rna_pkg::CHAR_W'(CHAR_ALPHA - DECIMAL_DIGITS + digits[k]);
            else
                c.ch = rna_pkg::CHAR_W'(CHAR_DIGIT0 + digits[k]);
            c.last = (k == 0);
            expected_chars.push_back(c);
        end
    endtask

    // Driver: offers queued values, holds each until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_number_in <= '0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                spell_number(s_number_in, radix_now);
                values_taken++;
            end
            if (value_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_valid     <= 1'b1;
                s_number_in <= value_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each character and paces m_ready
    always @(posedge aclk) begin
        ascii_char_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected character, expected none actual %0d last %0d",
                                 $time, m_digit_char, m_last_char);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_digit_char !== want.ch) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: digit_char mismatch, expected %0d actual %0d",
                                     $time, want.ch, m_digit_char);
                    end
                    if (m_last_char !== want.last) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: last_char mismatch, expected %0d actual %0d",
                                     $time, want.last, m_last_char);
                    end
                end
                chars_checked++;
            end
            // one long hold-off while the driver still has values waiting
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && !calm && value_q.size() > 3) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Radix write, only while the converter is idle
    task automatic write_radix(input logic [rna_pkg::RADIX_W-1:0] r);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= r;
        radix_now   = r;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        radix_writes++;
        @(negedge aclk);
    endtask

    // Wait until all values are taken and spelled out, then let it settle
    task automatic wait_idle();
        while (value_q.size() != 0 || s_valid || expected_chars.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [rna_pkg::NUMBER_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 40);
            2:       return $urandom >> $urandom_range(1, 31);
            default: return {rna_pkg::NUMBER_W{1'b1}} - $urandom_range(0, 3);
        endcase
    endfunction

    // Stimulus
    initial begin
        logic [rna_pkg::RADIX_W-1:0] r;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset radix (decimal)
        value_q = '{32'd0, 32'd1, 32'd9, 32'd10, 32'hFFFF_FFFF, 32'd1000000000, 32'd12345};
        wait_idle();

        // binary: longest strings
        write_radix(rna_pkg::RADIX_MIN);
        value_q = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
        wait_idle();

        // base 32: highest digit character
        write_radix(rna_pkg::RADIX_MAX);
        value_q = '{32'd31, 32'd32, 32'hFFFF_FFFF, 32'd0};
        wait_idle();

        write_radix(6'd16);
        value_q = '{32'hDEAD_BEEF, 32'h89AB_CDEF, 32'd15};
        wait_idle();

        // illegal radix values: items are taken, nothing comes out
        write_radix(6'd1);
        value_q = '{32'd5, 32'd0};
        wait_idle();
        write_radix(6'd0);
        value_q.push_back(32'd77);
        wait_idle();
        write_radix(6'd33);
        value_q.push_back(32'hFFFF_FFFF);
        wait_idle();
        write_radix(6'd63);
        value_q.push_back(32'd123);
        wait_idle();

        // random phases; the first one runs with no idling on either side
        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       r = rna_pkg::RADIX_MIN;
                1:       r = rna_pkg::RADIX_MAX;
                default: r = rna_pkg::RADIX_W'($urandom_range(rna_pkg::RADIX_MIN,
                                                              rna_pkg::RADIX_MAX));
            endcase
            write_radix(r);
            calm = (p == 0);
            repeat (21) value_q.push_back(pick_value());
            wait_idle();
        end
        calm = 1'b0;

        if (expected_chars.size() != 0)
            error_count++;
        $display("Converted %0d values into %0d characters", values_taken, chars_checked);
        $display("across %0d radix writes, including both range ends and illegal bases",
                 radix_writes);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
